@@ rtl/core/tkn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkn_pkg
// shared types, token codes and character helpers for the source tokenizer
// ----------------------------------------------------------------------------
package tkn_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  localparam off_t OFF_MAX = '1;
  localparam len_t LEN_MAX = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_LPAREN = 6'd1;
  localparam logic [5:0] K_RPAREN = 6'd2;
  localparam logic [5:0] K_LBRACE = 6'd3;
  localparam logic [5:0] K_RBRACE = 6'd4;
  localparam logic [5:0] K_LBRACK = 6'd5;
  localparam logic [5:0] K_RBRACK = 6'd6;
  localparam logic [5:0] K_COMMA  = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_COLON  = 6'd9;
  localparam logic [5:0] K_PLUS   = 6'd10;
  localparam logic [5:0] K_PLUSEQ = 6'd11;
  localparam logic [5:0] K_MINUS  = 6'd12;
  localparam logic [5:0] K_MINEQ  = 6'd13;
  localparam logic [5:0] K_STAR   = 6'd14;
  localparam logic [5:0] K_STAREQ = 6'd15;
  localparam logic [5:0] K_SLASH  = 6'd16;
  localparam logic [5:0] K_SLASHEQ = 6'd17;
  localparam logic [5:0] K_PERCENT = 6'd18;
  localparam logic [5:0] K_ASSIGN = 6'd19;
  localparam logic [5:0] K_EQ     = 6'd20;
  localparam logic [5:0] K_NOT    = 6'd21;
  localparam logic [5:0] K_NE     = 6'd22;
  localparam logic [5:0] K_LT     = 6'd23;
  localparam logic [5:0] K_LE     = 6'd24;
  localparam logic [5:0] K_GT     = 6'd25;
  localparam logic [5:0] K_GE     = 6'd26;
  localparam logic [5:0] K_ANDAND = 6'd27;
  localparam logic [5:0] K_OROR   = 6'd28;
  localparam logic [5:0] K_STRING = 6'd29;
  localparam logic [5:0] K_NUMBER = 6'd30;
  localparam logic [5:0] K_FLOAT  = 6'd31;
  localparam logic [5:0] K_IDENT  = 6'd32;
  localparam logic [5:0] K_INT    = 6'd33;
  localparam logic [5:0] K_CHAR   = 6'd34;
  localparam logic [5:0] K_VOID   = 6'd35;
  localparam logic [5:0] K_IF     = 6'd36;
  localparam logic [5:0] K_ELSE   = 6'd37;
  localparam logic [5:0] K_WHILE  = 6'd38;
  localparam logic [5:0] K_FOR    = 6'd39;
  localparam logic [5:0] K_RETURN = 6'd40;
  localparam logic [5:0] K_PRINT  = 6'd41;
  localparam logic [5:0] K_READ   = 6'd42;

  localparam logic [47:0] KW_INT    = 48'h0000_0069_6e74;
  localparam logic [47:0] KW_FLOAT  = 48'h0066_6c6f_6174;
  localparam logic [47:0] KW_CHAR   = 48'h0000_6368_6172;
  localparam logic [47:0] KW_VOID   = 48'h0000_766f_6964;
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_ELSE   = 48'h0000_656c_7365;
  localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6c65;
  localparam logic [47:0] KW_FOR    = 48'h0000_0066_6f72;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726e;
  localparam logic [47:0] KW_PRINT  = 48'h0070_7269_6e74;
  localparam logic [47:0] KW_READ   = 48'h0000_7265_6164;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7c;

  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } char_word_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] lexeme_length;
    logic [23:0] line_number;
    logic        error;
    logic        last_result;
  } token_word_t;

  typedef struct packed {
    logic [1:0]  count;
    token_word_t r0;
    token_word_t r1;
  } scan_res_t;

  typedef struct packed {
    logic                 room;
    logic [QLVL_BITS-1:0] level;
  } queue_stat_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic [23:0] off_out(off_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[23:0];
  endfunction

  function automatic logic [15:0] len_out(len_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic off_t off_inc(off_t v);
    return (v == OFF_MAX) ? v : v + off_t'(1);
  endfunction

  function automatic len_t len_inc(len_t v);
    return (v == LEN_MAX) ? v : v + len_t'(1);
  endfunction

  function automatic len_t len_inc2(len_t v);
    return (v >= LEN_MAX - len_t'(1)) ? LEN_MAX : v + len_t'(2);
  endfunction

  function automatic logic [5:0] keyword_kind(logic [47:0] kbuf);
    logic [5:0] k;
    case (kbuf)
      KW_INT:    k = K_INT;
      KW_FLOAT:  k = K_FLOAT;
      KW_CHAR:   k = K_CHAR;
      KW_VOID:   k = K_VOID;
      KW_IF:     k = K_IF;
      KW_ELSE:   k = K_ELSE;
      KW_WHILE:  k = K_WHILE;
      KW_FOR:    k = K_FOR;
      KW_RETURN: k = K_RETURN;
      KW_PRINT:  k = K_PRINT;
      KW_READ:   k = K_READ;
      default:   k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      ",":     k = K_COMMA;
      ";":     k = K_SEMI;
      ":":     k = K_COLON;
      "%":     k = K_PERCENT;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic is_op_start(logic [7:0] c);
    return c inside {"+", "-", "*", "/", "=", "!", "<", ">", "&", "|"};
  endfunction

  // single-character kind, K_END for a lone & or |
  function automatic logic [5:0] op_one(logic [7:0] p);
    logic [5:0] k;
    case (p)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "=":     k = K_ASSIGN;
      "!":     k = K_NOT;
      "<":     k = K_LT;
      ">":     k = K_GT;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_two(logic [7:0] p);
    logic [5:0] k;
    case (p)
      "+":     k = K_PLUSEQ;
      "-":     k = K_MINEQ;
      "*":     k = K_STAREQ;
      "/":     k = K_SLASHEQ;
      "=":     k = K_EQ;
      "!":     k = K_NE;
      "<":     k = K_LE;
      ">":     k = K_GE;
      "&":     k = K_ANDAND;
      default: k = K_OROR;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_second(logic [7:0] p);
    logic [7:0] s;
    case (p)
      "&":     s = CH_AMP;
      "+", "-", "*", "/", "=", "!", "<", ">": s = CH_EQ;
      default: s = CH_BAR;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/tkn_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkn_scan
// scanner state and per-byte decision logic, up to two tokens per word
// ----------------------------------------------------------------------------
module tkn_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  tkn_pkg::char_word_t word,
  output tkn_pkg::scan_res_t  res
);
  import tkn_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_NUM    = 3'd2,
    M_NUMDOT = 3'd3,
    M_FLOAT  = 3'd4,
    M_STR    = 3'd5,
    M_OP     = 3'd6
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  pending, pending_next;
  off_t        position, position_next;
  off_t        line, line_next;
  off_t        tstart, tstart_next;
  len_t        tlen, tlen_next;
  logic [47:0] kbuf, kbuf_next;

  function automatic token_word_t mk(logic [5:0] k, off_t s, len_t l, logic e, off_t ln);
    token_word_t t;
    t.token_kind    = k;
    t.start_offset  = off_out(s);
    t.lexeme_length = len_out(l);
    t.line_number   = off_out(ln);
    t.error         = e;
    t.last_result   = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic        f_valid;
    logic [5:0]  f_kind;
    len_t        f_len;
    logic        do_flush;
    logic        do_idle;
    logic        first_valid;
    token_word_t first_tok;
    logic        second_valid;
    token_word_t second_tok;
    logic [5:0]  pk;

    c             = word.char_byte;
    mode_next     = mode;
    pending_next  = pending;
    position_next = position;
    line_next     = line;
    tstart_next   = tstart;
    tlen_next     = tlen;
    kbuf_next     = kbuf;
    do_flush      = 1'b0;
    do_idle       = 1'b0;
    first_valid   = 1'b0;
    first_tok     = '0;
    second_valid  = 1'b0;
    second_tok    = '0;
    pk            = K_END;
    res           = '0;

    // token held in the scanner, if the current word ends it
    f_valid = 1'b1;
    f_len   = tlen;
    case (mode)
      M_IDENT:  f_kind = (tlen > len_t'(6)) ? K_IDENT : keyword_kind(kbuf);
      M_NUM,
      M_NUMDOT: f_kind = K_NUMBER;
      M_FLOAT:  f_kind = K_FLOAT;
      M_OP: begin
        f_kind  = op_one(pending);
        f_len   = len_t'(1);
        f_valid = (f_kind != K_END);
      end
      default: begin
        f_kind  = K_END;
        f_valid = 1'b0;
      end
    endcase

    if (word.action) begin
      if (mode == M_STR) begin
        first_valid = 1'b1;
        first_tok   = mk(K_END, tstart, tlen, 1'b1, line);
      end else begin
        first_valid  = f_valid;
        first_tok    = mk(f_kind, tstart, f_len, 1'b0, line);
        second_valid = 1'b1;
        second_tok   = mk(K_END, position, '0, 1'b0, line);
      end
      mode_next     = M_IDLE;
      pending_next  = '0;
      position_next = '0;
      line_next     = off_t'(1);
      tstart_next   = '0;
      tlen_next     = '0;
      kbuf_next     = '0;
    end else begin
      position_next = off_inc(position);
      case (mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            if (tlen < len_t'(6)) kbuf_next = {kbuf[39:0], c};
            tlen_next = len_inc(tlen);
          end else begin
            do_flush = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            tlen_next = len_inc(tlen);
          end else if (c == CH_DOT) begin
            mode_next = M_NUMDOT;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(c)) begin
            mode_next = M_FLOAT;
            tlen_next = len_inc2(tlen);
          end else begin
            do_flush = 1'b1;
          end
        end
        M_FLOAT: begin
          if (is_digit(c)) begin
            tlen_next = len_inc(tlen);
          end else begin
            do_flush = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            first_valid = 1'b1;
            first_tok   = mk(K_STRING, tstart, tlen, 1'b0, line);
            mode_next   = M_IDLE;
          end else begin
            if (c == CH_NL) line_next = off_inc(line);
            tlen_next = len_inc(tlen);
          end
        end
        M_OP: begin
          if (c == op_second(pending)) begin
            first_valid = 1'b1;
            first_tok   = mk(op_two(pending), tstart, len_t'(2), 1'b0, line);
            mode_next   = M_IDLE;
          end else begin
            do_flush = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_flush) begin
        first_valid = f_valid;
        first_tok   = mk(f_kind, tstart, f_len, 1'b0, line);
        do_idle     = 1'b1;
      end

      if (do_idle) begin
        pk        = punct_kind(c);
        mode_next = M_IDLE;
        if (pk != K_END) begin
          second_valid = 1'b1;
          second_tok   = mk(pk, position, len_t'(1), 1'b0, line);
        end else if (is_op_start(c)) begin
          mode_next    = M_OP;
          pending_next = c;
          tstart_next  = position;
          tlen_next    = len_t'(1);
        end else if (c == CH_QUOTE) begin
          mode_next   = M_STR;
          tstart_next = off_inc(position);
          tlen_next   = '0;
        end else if (c == CH_NL) begin
          line_next = off_inc(line);
        end else if (is_digit(c)) begin
          mode_next   = M_NUM;
          tstart_next = position;
          tlen_next   = len_t'(1);
        end else if (is_alpha(c) || c == CH_UNDER) begin
          mode_next   = M_IDENT;
          tstart_next = position;
          tlen_next   = len_t'(1);
          kbuf_next   = {40'd0, c};
        end
      end
    end

    if (accept) begin
      if (first_valid) begin
        res.r0 = first_tok;
        res.r1 = second_tok;
        res.count = second_valid ? 2'd2 : 2'd1;
        if (second_valid) res.r1.last_result = 1'b1;
        else res.r0.last_result = 1'b1;
      end else if (second_valid) begin
        res.r0 = second_tok;
        res.r0.last_result = 1'b1;
        res.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      pending  <= '0;
      position <= '0;
      line     <= off_t'(1);
      tstart   <= '0;
      tlen     <= '0;
      kbuf     <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      pending  <= pending_next;
      position <= position_next;
      line     <= line_next;
      tstart   <= tstart_next;
      tlen     <= tlen_next;
      kbuf     <= kbuf_next;
    end
  end

endmodule

@@ rtl/core/tkn_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkn_queue
// small result queue, takes up to two tokens a cycle and hands out one while token_ready is high
// ----------------------------------------------------------------------------
module tkn_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  tkn_pkg::scan_res_t   res,
  output logic                 token_valid,
  input  logic                 token_ready,
  output tkn_pkg::token_word_t token_data,
  output tkn_pkg::queue_stat_t stat
);
  import tkn_pkg::*;

  typedef logic [QPTR_BITS-1:0] ptr_t;
  typedef logic [QLVL_BITS-1:0] lvl_t;

  token_word_t mem [QUEUE_DEPTH];
  ptr_t        wr_ptr;
  ptr_t        rd_ptr;
  lvl_t        level;
  logic        pop;
  ptr_t        wr_ptr1;

  assign pop         = token_valid && token_ready;
  assign token_valid = (level != '0);
  assign token_data  = mem[rd_ptr];
  assign wr_ptr1     = wr_ptr + ptr_t'(1);
  assign stat.room   = (level <= lvl_t'(QUEUE_DEPTH - 2));
  assign stat.level  = level;

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) mem[wr_ptr] <= res.r0;
    if (res.count == 2'd2) mem[wr_ptr1] <= res.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ptr_t'(res.count);
      rd_ptr <= rd_ptr + ptr_t'(pop);
      level  <= level + lvl_t'(res.count) - lvl_t'(pop);
    end
  end

endmodule

@@ rtl/core/source_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer
// streaming lexer for a small c-like language, one source byte per word
// ----------------------------------------------------------------------------
// char channel: one word per source byte (action 0) or end of source (action 1)
// token channel: one word per token with kind, start offset, length, line,
//   error flag and a flag on the last token caused by a char word
// order: the tokens of a char word are registered into the result queue when
//   the word is taken and leave it in order; a second token from the same word
//   follows the first
// throughput: one char word per cycle while tokens drain at the same pace;
//   a word can give two tokens, so a four-entry result queue absorbs bursts
//   and char_ready drops while it holds more than two tokens
// reset: scanner returns to idle at offset 0, line 1 and the queue empties;
//   the scanner alone does the same after every end-of-source word
// stall: a held token_ready fills the queue, then char_ready goes low; no
//   token is lost or repeated
// ----------------------------------------------------------------------------
module source_tokenizer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  tkn_pkg::char_word_t  char_data,
  output logic                 token_valid,
  input  logic                 token_ready,
  output tkn_pkg::token_word_t token_data
);
  import tkn_pkg::*;

  scan_res_t   res;
  queue_stat_t stat;
  logic        accept;

  assign char_ready = stat.room;
  assign accept     = char_valid && char_ready;

  tkn_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (char_data),
    .res    (res)
  );

  tkn_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data),
    .stat        (stat)
  );

`ifndef NO_ASSERTIONS
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    res.count != 2'd0 |-> accept)
    else $error("tokens produced without an accepted word");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stat.level <= QLVL_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !token_valid)
    else $error("token offered right after reset");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_data.token_kind == K_END && !token_data.error
      |-> token_data.last_result && token_data.lexeme_length == 16'd0)
    else $error("end token not last or with length");
`endif

endmodule
